@@ hw/rtl/catmull_rom_point_2d_macros.svh @@
// assertion macros for the catmull-rom point evaluator
`ifndef CATMULL_ROM_POINT_2D_MACROS_SVH
`define CATMULL_ROM_POINT_2D_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked on every rising edge outside reset
`define CRP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("catmull_rom_point_2d assertion failed");
// next-cycle implication
`define CRP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("catmull_rom_point_2d assertion failed");
`else
`define CRP_ASSERT_IMPL(label, ante, cons)
`define CRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/crp_pkg.sv @@
// shared types and constants for the catmull-rom point evaluator
`timescale 1ns / 1ps

package crp_pkg;

	// coordinate format, signed fixed point
	localparam int COORD_W = 32;
	// curve parameter, unsigned q1.16, one integer bit so that 1.0 fits
	localparam int T_FRAC = 16;
	localparam int T_W = T_FRAC + 1;
	// horner accumulator: coefficient sums stay below 24 * 2^(COORD_W-1)
	localparam int ACC_W = COORD_W + 6;
	// signed accumulator times zero-extended parameter
	localparam int PROD_W = ACC_W + T_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'sd1 <<< (T_FRAC - 1));
	// coefficient stage + three horner steps of two stages + output stage
	localparam int PIPE_LATENCY = 8;

	typedef struct packed {
		logic [T_W-1:0]             t_param;
		logic signed [COORD_W-1:0]  p0_x;
		logic signed [COORD_W-1:0]  p0_y;
		logic signed [COORD_W-1:0]  p1_x;
		logic signed [COORD_W-1:0]  p1_y;
		logic signed [COORD_W-1:0]  p2_x;
		logic signed [COORD_W-1:0]  p2_y;
		logic signed [COORD_W-1:0]  p3_x;
		logic signed [COORD_W-1:0]  p3_y;
	} crp_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
	} crp_out_t;

	// one coordinate in flight: running sum and the addends still to come
	typedef struct packed {
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] add0;
		logic signed [ACC_W-1:0] add1;
		logic signed [ACC_W-1:0] add2;
	} crp_lane_t;

	typedef struct packed {
		logic [T_W-1:0] t;
		crp_lane_t      x;
		crp_lane_t      y;
	} crp_work_t;

endpackage

@@ hw/rtl/crp_coef.sv @@
// input stage: parameter clamp and spline coefficients for both coordinates
`timescale 1ns / 1ps

module crp_coef (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  crp_pkg::crp_in_t   item,
	output logic               out_valid,
	output crp_pkg::crp_work_t out_work
);

	logic               valid_s1;
	crp_pkg::crp_work_t work_s1;
	crp_pkg::crp_work_t work_next;

	function automatic crp_pkg::crp_lane_t coefs(
		input logic signed [crp_pkg::COORD_W-1:0] p0,
		input logic signed [crp_pkg::COORD_W-1:0] p1,
		input logic signed [crp_pkg::COORD_W-1:0] p2,
		input logic signed [crp_pkg::COORD_W-1:0] p3
	);
		logic signed [crp_pkg::ACC_W-1:0] e0;
		logic signed [crp_pkg::ACC_W-1:0] e1;
		logic signed [crp_pkg::ACC_W-1:0] e2;
		logic signed [crp_pkg::ACC_W-1:0] e3;
		crp_pkg::crp_lane_t lane;
		e0 = crp_pkg::ACC_W'(p0);
		e1 = crp_pkg::ACC_W'(p1);
		e2 = crp_pkg::ACC_W'(p2);
		e3 = crp_pkg::ACC_W'(p3);
		// horner order: d first, then c, b, a
		lane.acc  = (e1 <<< 1) + e1 + e3 - e0 - (e2 <<< 1) - e2;
		lane.add0 = (e0 <<< 1) + (e2 <<< 2) - (e1 <<< 2) - e1 - e3;
		lane.add1 = e2 - e0;
		lane.add2 = e1 <<< 1;
		return lane;
	endfunction

	always_comb begin
		// anything above 1.0 is treated as 1.0
		if (item.t_param[crp_pkg::T_W-1] && (item.t_param[crp_pkg::T_FRAC-1:0] != '0)) begin
			work_next.t = crp_pkg::T_W'(1) << crp_pkg::T_FRAC;
		end else begin
			work_next.t = item.t_param;
		end
		work_next.x = coefs(item.p0_x, item.p1_x, item.p2_x, item.p3_x);
		work_next.y = coefs(item.p0_y, item.p1_y, item.p2_y, item.p3_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		work_s1 <= work_next;
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

@@ hw/rtl/crp_horner_step.sv @@
// one horner step: multiply by t, then round and add the next coefficient
`timescale 1ns / 1ps

module crp_horner_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  crp_pkg::crp_work_t in_work,
	output logic               out_valid,
	output crp_pkg::crp_work_t out_work
);

	logic signed [crp_pkg::PROD_W-1:0] prod_x;
	logic signed [crp_pkg::PROD_W-1:0] prod_y;
	logic signed [crp_pkg::PROD_W-1:0] prod_x_s1;
	logic signed [crp_pkg::PROD_W-1:0] prod_y_s1;
	logic                              valid_s1;
	crp_pkg::crp_work_t                work_s1;
	logic signed [crp_pkg::PROD_W-1:0] rnd_x;
	logic signed [crp_pkg::PROD_W-1:0] rnd_y;
	crp_pkg::crp_work_t                work_next;
	logic                              valid_s2;
	crp_pkg::crp_work_t                work_s2;

	// stage 1: signed accumulator times non-negative parameter
	assign prod_x = crp_pkg::PROD_W'(in_work.x.acc)
		* crp_pkg::PROD_W'($signed({1'b0, in_work.t}));
	assign prod_y = crp_pkg::PROD_W'(in_work.y.acc)
		* crp_pkg::PROD_W'($signed({1'b0, in_work.t}));

	// stage 2: round half up to the coordinate scale, add next coefficient
	assign rnd_x = (prod_x_s1 + crp_pkg::ROUND_HALF) >>> crp_pkg::T_FRAC;
	assign rnd_y = (prod_y_s1 + crp_pkg::ROUND_HALF) >>> crp_pkg::T_FRAC;

	always_comb begin
		work_next.t      = work_s1.t;
		work_next.x.acc  = $signed(rnd_x[crp_pkg::ACC_W-1:0]) + work_s1.x.add0;
		work_next.x.add0 = work_s1.x.add1;
		work_next.x.add1 = work_s1.x.add2;
		work_next.x.add2 = '0;
		work_next.y.acc  = $signed(rnd_y[crp_pkg::ACC_W-1:0]) + work_s1.y.add0;
		work_next.y.add0 = work_s1.y.add1;
		work_next.y.add1 = work_s1.y.add2;
		work_next.y.add2 = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_x_s1 <= prod_x;
		prod_y_s1 <= prod_y;
		work_s1   <= in_work;
		work_s2   <= work_next;
	end

	assign out_valid = valid_s2;
	assign out_work  = work_s2;

endmodule

@@ hw/rtl/crp_round_sat.sv @@
// output stage: halve with round half up, saturate, register the result
`timescale 1ns / 1ps

module crp_round_sat (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  crp_pkg::crp_work_t in_work,
	output logic               done,
	output crp_pkg::crp_out_t  result
);

	logic              valid_q;
	crp_pkg::crp_out_t result_q;
	crp_pkg::crp_out_t result_next;

	function automatic logic signed [crp_pkg::COORD_W-1:0] halve_sat(
		input logic signed [crp_pkg::ACC_W-1:0] acc
	);
		logic signed [crp_pkg::ACC_W-1:0]         half;
		logic [crp_pkg::ACC_W-crp_pkg::COORD_W:0] top;
		half = (acc + crp_pkg::ACC_W'(1)) >>> 1;
		top  = half[crp_pkg::ACC_W-1:crp_pkg::COORD_W-1];
		if ((top == '0) || (top == '1)) begin
			halve_sat = half[crp_pkg::COORD_W-1:0];
		end else if (half[crp_pkg::ACC_W-1]) begin
			halve_sat = {1'b1, {(crp_pkg::COORD_W-1){1'b0}}};
		end else begin
			halve_sat = {1'b0, {(crp_pkg::COORD_W-1){1'b1}}};
		end
	endfunction

	always_comb begin
		result_next.x_out = halve_sat(in_work.x.acc);
		result_next.y_out = halve_sat(in_work.y.acc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_next;
	end

	assign done   = valid_q;
	assign result = result_q;

endmodule

@@ hw/rtl/catmull_rom_point_2d.sv @@
// top level of the catmull-rom spline point evaluator
`timescale 1ns / 1ps
//
//  channel   handshake          payload               direction
//  -------   ----------------   -------------------   ---------
//  input     start, busy        item   (crp_in_t)     in
//  result    done (strobe)      result (crp_out_t)    out
//
//  done follows an accepted start through the coefficient, horner and output registers
//  a new transaction can start in every cycle; busy stays low
//  the 8 stages: coefficients, three multiply/round-add pairs, output
//  the result is shown for one cycle only and must be taken then
//  reset clears only the valid bits of the stages, not the data

`include "catmull_rom_point_2d_macros.svh"

module catmull_rom_point_2d (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  crp_pkg::crp_in_t  item,
	output logic              done,
	output crp_pkg::crp_out_t result
);

	localparam int STEPS = 3;

	// valid bit and payload between the stages
	logic               step_valid [0:STEPS];
	crp_pkg::crp_work_t step_work  [0:STEPS];
	logic               accept;

	// nothing ever holds the pipe, so a transaction is taken whenever offered
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// coefficients a, b, c, d and the clamped parameter
	crp_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.item      (item),
		.out_valid (step_valid[0]),
		.out_work  (step_work[0])
	);

	// horner chain: acc = R(acc * t) + next coefficient, three times
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		crp_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (step_valid[i]),
			.in_work   (step_work[i]),
			.out_valid (step_valid[i+1]),
			.out_work  (step_work[i+1])
		);
	end

	// final halving and clamp to the coordinate range
	crp_round_sat u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (step_valid[STEPS]),
		.in_work  (step_work[STEPS]),
		.done     (done),
		.result   (result)
	);

	// every strobe comes from a transaction taken a fixed latency earlier
	`CRP_ASSERT_IMPL(a_done_has_source, done, $past(accept, crp_pkg::PIPE_LATENCY))

	// at t = 0 the curve sits exactly on the segment start
	`CRP_ASSERT_IMPL(a_t_zero_gives_p1, done && $past(accept && (item.t_param == '0), crp_pkg::PIPE_LATENCY), (result.x_out == $past(item.p1_x, crp_pkg::PIPE_LATENCY)) && (result.y_out == $past(item.p1_y, crp_pkg::PIPE_LATENCY)))

	// at t = 1.0 or above the curve sits exactly on the segment end
	`CRP_ASSERT_IMPL(a_t_one_gives_p2, done && $past(accept && item.t_param[crp_pkg::T_W-1], crp_pkg::PIPE_LATENCY), (result.x_out == $past(item.p2_x, crp_pkg::PIPE_LATENCY)) && (result.y_out == $past(item.p2_y, crp_pkg::PIPE_LATENCY)))

endmodule

@@ tb/tb_top.sv @@
// testbench for the catmull-rom spline point evaluator
`timescale 1ns / 1ps

module tb_top;
	import crp_pkg::*;

	// run-away guard, set far above the length of a correct run
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_POINTS = 1850;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 8;
	localparam int T_ONE = 1 << T_FRAC;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	crp_in_t  item;
	logic     done;
	crp_out_t result;

	// points predicted for accepted transactions, oldest first
	crp_out_t expected_points[$];
	int       mismatch_count;
	int       cycle_count;

	catmull_rom_point_2d dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run-away guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	// v * t / 2^16, rounded half up; magnitudes stay well inside 64 bits
	function automatic longint scale_by_t(longint v, longint t);
		return (v * t + (64'sd1 <<< (T_FRAC - 1))) >>> T_FRAC;
	endfunction

	function automatic logic signed [COORD_W-1:0] spline_coord(
		longint t,
		logic signed [COORD_W-1:0] q0, logic signed [COORD_W-1:0] q1,
		logic signed [COORD_W-1:0] q2, logic signed [COORD_W-1:0] q3);
		longint c0, c1, c2, c3, a, b, c, d, acc, res, maxv, minv;
		c0 = q0;
		c1 = q1;
		c2 = q2;
		c3 = q3;
		a = 2 * c1;
		b = c2 - c0;
		c = 2 * c0 - 5 * c1 + 4 * c2 - c3;
		d = -c0 + 3 * c1 - 3 * c2 + c3;
		// horner form, rounding after every multiply by t
		acc = scale_by_t(d, t) + c;
		acc = scale_by_t(acc, t) + b;
		acc = scale_by_t(acc, t) + a;
		// halve with round half up
		res = (acc + 1) >>> 1;
		maxv = (64'sd1 <<< (COORD_W - 1)) - 1;
		minv = -maxv - 1;
		if (res > maxv)
			res = maxv;
		if (res < minv)
			res = minv;
		return res[COORD_W-1:0];
	endfunction

	function automatic crp_out_t predict_point(crp_in_t it);
		crp_out_t pt;
		longint   t;
		// parameters beyond 1.0 are clamped to 1.0
		t = (it.t_param > T_ONE) ? T_ONE : it.t_param;
		pt.x_out = spline_coord(t, it.p0_x, it.p1_x, it.p2_x, it.p3_x);
		pt.y_out = spline_coord(t, it.p0_y, it.p1_y, it.p2_y, it.p3_y);
		return pt;
	endfunction

	// ------------------------------------------------------------------
	// result checking: done is a one-cycle strobe, sampled at the edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		crp_out_t want;
		if (arst_n && done) begin
			if (expected_points.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h", $time, result.x_out,
					result.y_out);
				mismatch_count++;
			end else begin
				want = expected_points.pop_front();
				if (result.x_out !== want.x_out) begin
					$display("%0t: x_out mismatch expected %h actual %h", $time,
						want.x_out, result.x_out);
					mismatch_count++;
				end
				if (result.y_out !== want.y_out) begin
					$display("%0t: y_out mismatch expected %h actual %h", $time,
						want.y_out, result.y_out);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// one transaction: random idle gap, then hold start until accepted.
	// start stays high on a zero gap so transactions can go back to back
	task automatic send_point(crp_in_t it);
		int gap;
		gap = $urandom_range(0, 6);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		expected_points.push_back(predict_point(it));
	endtask

	function automatic crp_in_t make_point(logic [T_W-1:0] t,
		logic signed [COORD_W-1:0] x0, logic signed [COORD_W-1:0] y0,
		logic signed [COORD_W-1:0] x1, logic signed [COORD_W-1:0] y1,
		logic signed [COORD_W-1:0] x2, logic signed [COORD_W-1:0] y2,
		logic signed [COORD_W-1:0] x3, logic signed [COORD_W-1:0] y3);
		crp_in_t it;
		it.t_param = t;
		it.p0_x = x0;
		it.p0_y = y0;
		it.p1_x = x1;
		it.p1_y = y1;
		it.p2_x = x2;
		it.p2_y = y2;
		it.p3_x = x3;
		it.p3_y = y3;
		return it;
	endfunction

	// t mostly inside [0, 1), with the endpoints and over-range values mixed in
	function automatic logic [T_W-1:0] rand_t();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return T_W'(T_ONE);
			2:       return T_W'($urandom_range(T_ONE + 1, (1 << T_W) - 1));
			default: return T_W'($urandom_range(0, T_ONE - 1));
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		logic signed [COORD_W-1:0] v;
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 3))
					0: v = {1'b1, {(COORD_W-1){1'b0}}};
					1: v = {1'b0, {(COORD_W-1){1'b1}}};
					2: v = '0;
					default: v = '1;
				endcase
			end
			1, 2, 3: v = COORD_W'($urandom);
			// moderate coordinates, within about +-256.0
			default: v = COORD_W'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
		endcase
		return v;
	endfunction

	// a plausible path: control points clustered around a base position
	function automatic logic signed [COORD_W-1:0] near(logic signed [COORD_W-1:0] base);
		return base + COORD_W'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// t = 0 lands on p1, t = 1.0 lands on p2, over-range t clamps to p2; also t near both ends and at one half
	task automatic test_endpoints();
		logic signed [COORD_W-1:0] v[8];
		foreach (v[i]) v[i] = rand_coord();
		send_point(make_point('0, '0, '0, '0, '0, '0, '0, '0, '0));
		send_point(make_point('0, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]));
		send_point(make_point(T_W'(T_ONE), v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]));
		send_point(make_point(T_W'(T_ONE + 1), v[0], v[1], v[2], v[3], v[4], v[5], v[6],
			v[7]));
		send_point(make_point('1, v[7], v[6], v[5], v[4], v[3], v[2], v[1], v[0]));
		send_point(make_point(T_W'(1), v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]));
		send_point(make_point(T_W'(T_ONE - 1), v[0], v[1], v[2], v[3], v[4], v[5], v[6],
			v[7]));
		send_point(make_point(T_W'(T_ONE / 2), v[0], v[1], v[2], v[3], v[4], v[5], v[6],
			v[7]));
	endtask

	// all-extreme control points and alternating extremes drive both rails
	task automatic test_extremes();
		send_point(make_point(T_W'(T_ONE / 2), C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX,
			C_MAX, C_MAX));
		send_point(make_point(T_W'(T_ONE / 2), C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN,
			C_MIN, C_MIN));
		send_point(make_point(T_W'(T_ONE / 2), C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX,
			C_MAX, C_MIN));
		send_point(make_point(T_W'(T_ONE / 4), C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MIN,
			C_MIN, C_MAX));
		send_point(make_point(T_W'(3 * T_ONE / 4), C_MIN, C_MAX, C_MAX, C_MIN, C_MIN,
			C_MAX, C_MAX, C_MIN));
		send_point(make_point(T_W'(T_ONE / 3), C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX,
			C_MIN, C_MAX));
		send_point(make_point(T_W'(T_ONE - 1), '1, '1, '1, '1, '1, '1, '1, '1));
		send_point(make_point(T_W'(T_ONE - 1), C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN,
			C_MAX, C_MIN));
	endtask

	// tiny values where the round-half-up steps decide the last bit
	task automatic test_rounding();
		send_point(make_point(T_W'(T_ONE / 2), '0, '0, 1, -1, '0, '0, '0, '0));
		send_point(make_point(T_W'(T_ONE / 2), 1, -1, '0, '0, '0, '0, 1, -1));
		send_point(make_point(T_W'(1), -1, 1, 1, -1, -1, 1, 1, -1));
		send_point(make_point(T_W'(T_ONE / 2 + 1), 3, -3, -1, 1, 2, -2, -5, 5));
		send_point(make_point(T_W'(T_ONE / 2 - 1), -7, 7, 3, -3, -1, 1, 9, -9));
	endtask

	task automatic test_random();
		crp_in_t it;
		logic signed [COORD_W-1:0] bx, by;
		for (int n = 0; n < RANDOM_POINTS; n++) begin
			case ($urandom_range(0, 19))
				// independent coordinates, anything the fields allow
				0, 1, 2, 3, 4: it = make_point(rand_t(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord());
				// raw bits everywhere, t included
				5, 6: it = make_point(T_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
				// smooth path segments, the usual animation case
				default: begin
					bx = rand_coord();
					by = rand_coord();
					it = make_point(rand_t(), near(bx), near(by), near(bx), near(by),
						near(bx), near(by), near(bx), near(by));
				end
			endcase
			send_point(it);
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_endpoints();
		test_extremes();
		test_rounding();
		test_random();

		// last transaction accepted at this edge; stop offering work
		start <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		// let any stray strobe show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ catmull_rom_point_2d.f @@
+incdir+hw/rtl
hw/rtl/crp_pkg.sv
hw/rtl/crp_coef.sv
hw/rtl/crp_horner_step.sv
hw/rtl/crp_round_sat.sv
hw/rtl/catmull_rom_point_2d.sv
tb/tb_top.sv
